### src/cbe_pkg.sv
// Shared constants for the cubic Bezier easing evaluator.
// No dependencies; imported by the Newton step and the top level.
package cbe_pkg;

  localparam int BEZ_W3 = 3;
  localparam int BEZ_W6 = 6;
  localparam int GUESS_SCALE = 8;

  localparam logic [1:0] REG_CTRL1_X = 2'd0;
  localparam logic [1:0] REG_CTRL1_Y = 2'd1;
  localparam logic [1:0] REG_CTRL2_X = 2'd2;
  localparam logic [1:0] REG_CTRL2_Y = 2'd3;

  localparam logic signed [19:0] OUT_MAX = 20'sd524287;
  localparam logic signed [19:0] OUT_MIN = -20'sd524288;

endpackage

### src/cubic_bezier_ease_eval_top.sv
// Top level of the cubic Bezier easing evaluator: APB registers, Newton chain, y evaluation.
// Uses cbe_pkg and cbe_newton_step.
//
// Takes one progress beat per clock while the output is not stalled and returns one eased
// value per beat, in order. The input register feeds the NEWTON_STEPS Newton stages,
// each with a one-bit-per-stage restoring divider, then the y evaluation registers.
// A stall on a held output beat freezes the whole pipeline; control points
// must be written while no beat is in flight.
module cubic_bezier_ease_eval_top import cbe_pkg::*; #(
  parameter int NEWTON_STEPS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [16:0]        progress,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] eased_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PW   = FRAC_BITS + 2;
  localparam int UW   = FRAC_BITS + 5;
  localparam int CXW  = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int YB   = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 4;
  localparam int YPRW = 2 * FRAC_BITS + 26;

  localparam logic [CXW-1:0]       ONE_C = CXW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;
  localparam logic signed [YB-1:0] ONE_Y = YB'(1) << FRAC_BITS;
  localparam logic signed [UW-1:0] GLIM  = UW'(GUESS_SCALE) << FRAC_BITS;

  function automatic logic signed [YPRW-1:0] qround(input logic signed [YPRW-1:0] p);
    logic [YPRW-1:0] m;
    m = p[YPRW-1] ? (~p + 1'b1) : p;
    m = (m + (YPRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[YPRW-1] ? -$signed(m) : $signed(m);
  endfunction

  // configuration
  logic [16:0]        ctrl1_x, ctrl2_x;
  logic signed [19:0] ctrl1_y, ctrl2_y;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1_x <= 17'd0;
      ctrl1_y <= 20'sd0;
      ctrl2_x <= 17'd65536;
      ctrl2_y <= 20'sd65536;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_CTRL1_X: ctrl1_x <= pwdata[16:0];
        REG_CTRL1_Y: ctrl1_y <= $signed(pwdata[19:0]);
        REG_CTRL2_X: ctrl2_x <= pwdata[16:0];
        REG_CTRL2_Y: ctrl2_y <= $signed(pwdata[19:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CTRL1_X: prdata = 32'(ctrl1_x);
      REG_CTRL1_Y: prdata = 32'(ctrl1_y);
      REG_CTRL2_X: prdata = 32'(ctrl2_x);
      REG_CTRL2_Y: prdata = 32'(ctrl2_y);
      default:     prdata = '0;
    endcase
  end

  logic [CXW-1:0]       ax_c, bx_c, t_c;
  logic signed [PW-1:0] ax, bx, t_sat;

  assign ax_c  = (CXW'(ctrl1_x) > ONE_C) ? ONE_C : CXW'(ctrl1_x);
  assign bx_c  = (CXW'(ctrl2_x) > ONE_C) ? ONE_C : CXW'(ctrl2_x);
  assign t_c   = (CXW'(progress) > ONE_C) ? ONE_C : CXW'(progress);
  assign ax    = $signed(PW'(ax_c));
  assign bx    = $signed(PW'(bx_c));
  assign t_sat = $signed(PW'(t_c));

  // pipeline flow
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic                 ch_valid [0:NEWTON_STEPS];
  logic signed [UW-1:0] ch_u     [0:NEWTON_STEPS];
  logic signed [PW-1:0] ch_t     [0:NEWTON_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_u[0] <= UW'(t_sat);
      ch_t[0] <= t_sat;
    end
  end

  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
    cbe_newton_step #(
      .FRAC_BITS(FRAC_BITS)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (ch_valid[i]),
      .u_in     (ch_u[i]),
      .t_in     (ch_t[i]),
      .ax       (ax),
      .bx       (bx),
      .out_valid(ch_valid[i+1]),
      .u_out    (ch_u[i+1]),
      .t_out    (ch_t[i+1])
    );
  end

  // y evaluation at the clamped parameter
  logic                 y1_valid, y2_valid, y3_valid, y4_valid;
  logic signed [PW-1:0] y1_u, y1_t;
  logic signed [PW-1:0] uf;

  always_comb begin
    if (ch_u[NEWTON_STEPS] < 0) begin
      uf = '0;
    end else if (ch_u[NEWTON_STEPS] > UW'(ONE_P)) begin
      uf = ONE_P;
    end else begin
      uf = PW'(ch_u[NEWTON_STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_u <= uf;
      y1_t <= ch_t[NEWTON_STEPS];
    end
  end

  logic signed [PW-1:0]   yv;
  logic signed [YPRW-1:0] r_uu, r_vv;
  logic signed [PW-1:0]   y2_u, y2_v, y2_uu, y2_vv, y2_t;

  assign yv   = ONE_P - y1_u;
  assign r_uu = qround(YPRW'(y1_u) * YPRW'(y1_u));
  assign r_vv = qround(YPRW'(yv) * YPRW'(yv));

  always_ff @(posedge clk) begin
    if (adv) begin
      y2_u  <= y1_u;
      y2_v  <= yv;
      y2_uu <= r_uu[PW-1:0];
      y2_vv <= r_vv[PW-1:0];
      y2_t  <= y1_t;
    end
  end

  logic signed [YPRW-1:0] r_m1, r_m2, r_m3;
  logic signed [PW-1:0]   y3_m1, y3_m2, y3_m3, y3_t;

  assign r_m1 = qround(YPRW'(y2_vv) * YPRW'(y2_u));
  assign r_m2 = qround(YPRW'(y2_v) * YPRW'(y2_uu));
  assign r_m3 = qround(YPRW'(y2_uu) * YPRW'(y2_u));

  always_ff @(posedge clk) begin
    if (adv) begin
      y3_m1 <= r_m1[PW-1:0];
      y3_m2 <= r_m2[PW-1:0];
      y3_m3 <= r_m3[PW-1:0];
      y3_t  <= y2_t;
    end
  end

  logic signed [YPRW-1:0] r_b1, r_b2;
  logic signed [YB-1:0]   y4_b1, y4_b2;
  logic signed [PW-1:0]   y4_m3, y4_t;

  assign r_b1 = qround(YPRW'(y3_m1) * YPRW'(ctrl1_y));
  assign r_b2 = qround(YPRW'(y3_m2) * YPRW'(ctrl2_y));

  always_ff @(posedge clk) begin
    if (adv) begin
      y4_b1 <= r_b1[YB-1:0];
      y4_b2 <= r_b2[YB-1:0];
      y4_m3 <= y3_m3;
      y4_t  <= y3_t;
    end
  end

  logic signed [YB-1:0] res, res_sel;
  logic signed [19:0]   res_sat;

  assign res = YB'(y4_b1) * YB'(BEZ_W3) + YB'(y4_b2) * YB'(BEZ_W3) + YB'(y4_m3);

  always_comb begin
    if (y4_t == '0) begin
      res_sel = '0;
    end else if (y4_t == ONE_P) begin
      res_sel = ONE_Y;
    end else begin
      res_sel = res;
    end
    if (res_sel > YB'(OUT_MAX)) begin
      res_sat = OUT_MAX;
    end else if (res_sel < YB'(OUT_MIN)) begin
      res_sat = OUT_MIN;
    end else begin
      res_sat = 20'(res_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eased_value <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid[0] <= 1'b0;
      y1_valid    <= 1'b0;
      y2_valid    <= 1'b0;
      y3_valid    <= 1'b0;
      y4_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      ch_valid[0] <= in_valid;
      y1_valid    <= ch_valid[NEWTON_STEPS];
      y2_valid    <= y1_valid;
      y3_valid    <= y2_valid;
      y4_valid    <= y3_valid;
      out_valid   <= y4_valid;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_held_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a held output beat");

  a_zero_progress: assert property (@(posedge clk) disable iff (rst)
    adv && y4_valid && (y4_t == '0) |=> out_valid && (eased_value == '0))
    else $error("zero progress did not give zero");

  a_guess_bounded: assert property (@(posedge clk) disable iff (rst)
    ch_valid[NEWTON_STEPS] |-> (ch_u[NEWTON_STEPS] <= GLIM) && (ch_u[NEWTON_STEPS] >= -GLIM))
    else $error("Newton guess out of range");
`endif

endmodule

### src/cbe_newton_step.sv
// One pipelined Newton-Raphson step u -= (Bx(u) - t) / Bx'(u).
// Uses cbe_pkg; bit-per-stage restoring divider for the quotient.
module cbe_newton_step import cbe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [FRAC_BITS+4:0]   u_in,
  input  logic signed [FRAC_BITS+1:0]   t_in,
  input  logic signed [FRAC_BITS+1:0]   ax,
  input  logic signed [FRAC_BITS+1:0]   bx,
  output logic                          out_valid,
  output logic signed [FRAC_BITS+4:0]   u_out,
  output logic signed [FRAC_BITS+1:0]   t_out
);

  localparam int UW   = FRAC_BITS + 5;
  localparam int PW   = FRAC_BITS + 2;
  localparam int SW   = FRAC_BITS + 8;
  localparam int CW   = FRAC_BITS + 11;
  localparam int AW   = FRAC_BITS + 14;
  localparam int PRW  = 2 * FRAC_BITS + 14;
  localparam int NW   = 2 * FRAC_BITS + 15;
  localparam int DW   = FRAC_BITS + 15;
  localparam int QB   = FRAC_BITS + 6;
  localparam int CMPW = 2 * FRAC_BITS + 21;
  localparam int XW   = FRAC_BITS + 8;

  localparam logic signed [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;
  localparam logic signed [XW-1:0] GLIM  = XW'(GUESS_SCALE) << FRAC_BITS;

  function automatic logic signed [PRW-1:0] qround(input logic signed [PRW-1:0] p);
    logic [PRW-1:0] m;
    m = p[PRW-1] ? (~p + 1'b1) : p;
    m = (m + (PRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[PRW-1] ? -$signed(m) : $signed(m);
  endfunction

  // stage 1: squares
  logic signed [UW-1:0]  v0;
  logic signed [PRW-1:0] r_uu, r_vv, r_vu;
  logic                  s1_valid;
  logic signed [UW-1:0]  s1_u, s1_v;
  logic signed [PW-1:0]  s1_t;
  logic signed [SW-1:0]  s1_uu, s1_vv, s1_vu;

  assign v0   = ONE_U - u_in;
  assign r_uu = qround(PRW'(u_in) * PRW'(u_in));
  assign r_vv = qround(PRW'(v0) * PRW'(v0));
  assign r_vu = qround(PRW'(v0) * PRW'(u_in));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u  <= u_in;
      s1_v  <= v0;
      s1_t  <= t_in;
      s1_uu <= r_uu[SW-1:0];
      s1_vv <= r_vv[SW-1:0];
      s1_vu <= r_vu[SW-1:0];
    end
  end

  // stage 2: cubes and slope terms
  logic signed [PW-1:0]  p21, onep2;
  logic signed [PRW-1:0] r_m1, r_m2, r_m3, r_s1, r_s2, r_s3;
  logic                  s2_valid;
  logic signed [UW-1:0]  s2_u;
  logic signed [PW-1:0]  s2_t;
  logic signed [CW-1:0]  s2_m1, s2_m2, s2_m3;
  logic signed [SW-1:0]  s2_s1, s2_s2, s2_s3;

  assign p21   = bx - ax;
  assign onep2 = ONE_P - bx;
  assign r_m1  = qround(PRW'(s1_vv) * PRW'(s1_u));
  assign r_m2  = qround(PRW'(s1_v) * PRW'(s1_uu));
  assign r_m3  = qround(PRW'(s1_uu) * PRW'(s1_u));
  assign r_s1  = qround(PRW'(s1_vv) * PRW'(ax));
  assign r_s2  = qround(PRW'(s1_vu) * PRW'(p21));
  assign r_s3  = qround(PRW'(s1_uu) * PRW'(onep2));

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_u  <= s1_u;
      s2_t  <= s1_t;
      s2_m1 <= r_m1[CW-1:0];
      s2_m2 <= r_m2[CW-1:0];
      s2_m3 <= r_m3[CW-1:0];
      s2_s1 <= r_s1[SW-1:0];
      s2_s2 <= r_s2[SW-1:0];
      s2_s3 <= r_s3[SW-1:0];
    end
  end

  // stage 3: weighted by control points
  logic signed [PRW-1:0] r_b1, r_b2;
  logic                  s3_valid;
  logic signed [UW-1:0]  s3_u;
  logic signed [PW-1:0]  s3_t;
  logic signed [CW-1:0]  s3_b1, s3_b2, s3_m3;
  logic signed [SW-1:0]  s3_s1, s3_s2, s3_s3;

  assign r_b1 = qround(PRW'(s2_m1) * PRW'(ax));
  assign r_b2 = qround(PRW'(s2_m2) * PRW'(bx));

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_u  <= s2_u;
      s3_t  <= s2_t;
      s3_b1 <= r_b1[CW-1:0];
      s3_b2 <= r_b2[CW-1:0];
      s3_m3 <= s2_m3;
      s3_s1 <= s2_s1;
      s3_s2 <= s2_s2;
      s3_s3 <= s2_s3;
    end
  end

  // stage 4: error, slope, divider operands
  logic signed [AW-1:0] err, slope;
  logic [AW-1:0]        an, ad;
  logic [NW-1:0]        num;
  logic [DW-1:0]        den;

  assign err   = AW'(s3_b1) * AW'(BEZ_W3) + AW'(s3_b2) * AW'(BEZ_W3) + AW'(s3_m3) - AW'(s3_t);
  assign slope = AW'(s3_s1) * AW'(BEZ_W3) + AW'(s3_s2) * AW'(BEZ_W6)
               + AW'(s3_s3) * AW'(BEZ_W3);
  assign an    = err[AW-1] ? (~err + 1'b1) : err;
  assign ad    = slope[AW-1] ? (~slope + 1'b1) : slope;
  assign num   = (NW'(an) << (FRAC_BITS + 1)) + NW'(ad);
  assign den   = DW'(ad) << 1;

  logic                 dv_valid [0:QB];
  logic [NW-1:0]        dv_rem   [0:QB];
  logic [DW-1:0]        dv_den   [0:QB];
  logic [QB-1:0]        dv_q     [0:QB];
  logic signed [UW-1:0] dv_u     [0:QB];
  logic signed [PW-1:0] dv_t     [0:QB];
  logic                 dv_neg   [0:QB];
  logic                 dv_ovf   [0:QB];
  logic                 dv_zero  [0:QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]  <= num;
      dv_den[0]  <= den;
      dv_q[0]    <= '0;
      dv_u[0]    <= s3_u;
      dv_t[0]    <= s3_t;
      dv_neg[0]  <= err[AW-1] ^ slope[AW-1];
      dv_ovf[0]  <= CMPW'(num) >= (CMPW'(den) << QB);
      dv_zero[0] <= (slope == '0);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int KB = QB - 1 - j;
    logic [CMPW-1:0] dsh;
    logic            ge;
    assign dsh = CMPW'(dv_den[j]) << KB;
    assign ge  = CMPW'(dv_rem[j]) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j+1]     <= ge ? (dv_rem[j] - dsh[NW-1:0]) : dv_rem[j];
        dv_den[j+1]     <= dv_den[j];
        dv_q[j+1]       <= dv_q[j] | (QB'(ge) << KB);
        dv_u[j+1]       <= dv_u[j];
        dv_t[j+1]       <= dv_t[j];
        dv_neg[j+1]     <= dv_neg[j];
        dv_ovf[j+1]     <= dv_ovf[j];
        dv_zero[j+1]    <= dv_zero[j];
      end
    end
  end

  // final stage: update and saturate the guess, or hold it when the slope is zero
  logic [QB-1:0]        qmag;
  logic signed [XW-1:0] qs, un;
  logic signed [UW-1:0] u_next;

  assign qmag = dv_ovf[QB] ? '1 : dv_q[QB];
  assign qs   = dv_neg[QB] ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
  assign un   = XW'(dv_u[QB]) - qs;

  always_comb begin
    if (dv_zero[QB]) begin
      u_next = dv_u[QB];
    end else if (un > GLIM) begin
      u_next = UW'(GLIM);
    end else if (un < -GLIM) begin
      u_next = UW'(-GLIM);
    end else begin
      u_next = UW'(un);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      dv_valid[0] <= 1'b0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      dv_valid[0] <= s3_valid;
      out_valid   <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_out <= u_next;
      t_out <= dv_t[QB];
    end
  end

endmodule

### bench/tb_top.sv
// Testbench for the cubic Bezier easing evaluator: APB control points, progress beats in,
// eased values out, checked against an in-bench fixed-point Newton solver. Needs cbe_pkg.
`timescale 1ns / 1ps

module tb_top;
  import cbe_pkg::*;

  localparam longint ONE = 64'sd65536;
  localparam int LATENCY = 222;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [16:0] progress = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] eased_value;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cubic_bezier_ease_eval_top dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  longint p1x = 0, p1y = 0, p2x = ONE, p2y = ONE;
  logic signed [19:0] eased_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = (mag(a) * mag(b) + 64'sd32768) >>> 16;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint q;
    q = (2 * mag(n) * ONE + mag(d)) / (2 * mag(d));
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint bez(longint a, longint b, longint u);
    longint v, uu, vv;
    v = ONE - u;
    uu = qmul(u, u);
    vv = qmul(v, v);
    return 3 * qmul(qmul(vv, u), a) + 3 * qmul(qmul(v, uu), b) + qmul(uu, u);
  endfunction

  function automatic longint bez_slope(longint a, longint b, longint u);
    longint v;
    v = ONE - u;
    return 3 * qmul(qmul(v, v), a) + 6 * qmul(qmul(v, u), b - a)
         + 3 * qmul(qmul(u, u), ONE - b);
  endfunction

  function automatic logic signed [19:0] ease(logic [16:0] prog);
    longint t, ax, bx, u, res, slope;
    t = prog > ONE ? ONE : longint'(prog);
    ax = p1x > ONE ? ONE : p1x;
    bx = p2x > ONE ? ONE : p2x;
    if (t == 0) res = 0;
    else if (t == ONE) res = ONE;
    else begin
      u = t;
      for (int i = 0; i < 8; i++) begin
        slope = bez_slope(ax, bx, u);
        if (slope == 0) break;
        u -= qdiv(bez(ax, bx, u) - t, slope);
        if (u > 8 * ONE) u = 8 * ONE;
        if (u < -8 * ONE) u = -8 * ONE;
      end
      if (u < 0) u = 0;
      if (u > ONE) u = ONE;
      res = bez(p1y, p2y, u);
    end
    if (res > 524287) res = 524287;
    if (res < -524288) res = -524288;
    return res[19:0];
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (eased_q.size() == 0) report("eased value with no beat pending");
      else begin
        logic signed [19:0] want;
        want = eased_q.pop_front();
        checked++;
        if (eased_value !== want)
          report($sformatf("eased_value got %0d want %0d", eased_value, want));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_progress(logic [16:0] prog);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    progress <= prog;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    eased_q.push_back(ease(prog));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (eased_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    case (idx)
      REG_CTRL1_X: p1x = longint'(val[16:0]);
      REG_CTRL1_Y: p1y = longint'($signed(val[19:0]));
      REG_CTRL2_X: p2x = longint'(val[16:0]);
      REG_CTRL2_Y: p2y = longint'($signed(val[19:0]));
    endcase
  endtask

  task automatic set_curve(longint ax, longint ay, longint bx, longint by);
    drain();
    apb_write(REG_CTRL1_X, 32'(ax));
    apb_write(REG_CTRL1_Y, 32'(ay));
    apb_write(REG_CTRL2_X, 32'(bx));
    apb_write(REG_CTRL2_Y, 32'(by));
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    logic [16:0] pts[$] = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536,
                            17'd65537, 17'h1FFFF, 17'h0AAAA, 17'h15555};
    set_curve(0, 0, ONE, ONE);
    foreach (pts[i]) send_progress(pts[i]);
    set_curve(131071, 262144, 131071, -262144);
    foreach (pts[i]) send_progress(pts[i]);
    set_curve(0, -262144, 0, 262144);
    foreach (pts[i]) send_progress(pts[i]);
  endtask

  task automatic random_curve();
    longint ax, bx, ay, by;
    ax = $urandom_range(4) == 0 ? $urandom_range(131071) : $urandom_range(65536);
    bx = $urandom_range(4) == 0 ? $urandom_range(131071) : $urandom_range(65536);
    ay = longint'($urandom_range(524288)) - 262144;
    by = longint'($urandom_range(524288)) - 262144;
    set_curve(ax, ay, bx, by);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) random_curve();
      if (i == n / 2) drain();
      send_progress($urandom_range(7) == 0 ? 17'($urandom) : 17'($urandom_range(65536)));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 16; recv_idle_pct = 84;
    test_directed();
    test_random(350);
    send_idle_pct = 84; recv_idle_pct = 16;
    test_random(350);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    drain();
    $display("sent %0d progress beats over directed and random curves, %0d checked",
             sent, checked);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
